// File: design/wit_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wit_pkg: shared constants for the window id table
// Table depth default, operation codes and status codes.
// ----------------------------------------------------------------------------
package wit_pkg;

    // default number of table entries
    localparam int WIT_ENTRIES = 32;

    // operation codes
    localparam logic [1:0] OP_CREATE = 2'd0;
    localparam logic [1:0] OP_MAP    = 2'd1;
    localparam logic [1:0] OP_UNMAP  = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_ZERO_ID   = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

endpackage
// ----------------------------------------------------------------------------
`default_nettype wire

// File: design/window_id_table_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// window_id_table_top: associative table of window entries keyed by id
// Each input word carries one operation (create/update, map, unmap, query)
// and returns one result word with a status and the mapped flag.
// ----------------------------------------------------------------------------
// Every input word passes through an accept state, a scan that reads each
// entry of the entry memory while the id match and the lowest free entry
// are tracked, and a finish state that waits for a free result register
// and then writes the modified entry back and loads the result. The scan
// always covers the whole table. Results sit in an output register, so a
// new word is taken while an earlier result still waits on o_out_valid.
// Valid marks are flip-flops cleared by reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module window_id_table_top
    import wit_pkg::*;
#(
    parameter int ENTRIES = WIT_ENTRIES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_op,
    input  wire logic [31:0] i_window_id,
    input  wire logic [15:0] i_surface,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic             o_mapped
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    typedef struct packed {
        logic [31:0] id;
        logic [15:0] surface;
        logic        mapped;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    // entry memory and valid marks
    t_entry               r_mem [ENTRIES];
    logic [ENTRIES-1:0]   r_valid;

    // control
    t_state               r_state;
    logic [IW-1:0]        r_addr;
    logic                 r_rd_vld;
    logic [IW-1:0]        r_rd_idx;
    t_entry               r_rd_word;

    // latched request
    logic [1:0]           r_op;
    logic [31:0]          r_key;
    logic [15:0]          r_surf;

    // scan results
    logic                 r_found;
    logic [IW-1:0]        r_hit_idx;
    t_entry               r_hit_word;
    logic                 r_free_found;
    logic [IW-1:0]        r_free_idx;

    // result register
    logic                 r_out_valid;
    logic [1:0]           r_status;
    logic                 r_mapped;

    logic                 in_accept;
    logic                 out_free;
    logic                 rd_match;
    logic                 hit_c;
    logic [IW-1:0]        hit_idx_c;
    t_entry               hit_word_c;
    logic                 wr_en;
    logic [IW-1:0]        wr_idx;
    t_entry               wr_word;
    logic                 set_valid;
    logic [1:0]           n_status;
    logic                 n_mapped;
    logic                 finish_go;

    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign finish_go  = (r_state == S_FINISH) && out_free;

    // match on the word read last cycle, folded with earlier hits
    always_comb begin
        rd_match   = r_rd_vld && r_valid[r_rd_idx] && (r_rd_word.id == r_key);
        hit_c      = r_found || rd_match;
        hit_idx_c  = r_found ? r_hit_idx  : r_rd_idx;
        hit_word_c = r_found ? r_hit_word : r_rd_word;
    end

    // write-back and result for the finishing word
    always_comb begin
        wr_en     = 1'b0;
        wr_idx    = hit_idx_c;
        wr_word   = hit_word_c;
        set_valid = 1'b0;
        n_status  = ST_OK;
        n_mapped  = 1'b0;
        case (r_op)
            OP_CREATE: begin
                if (r_key == 32'd0) begin
                    n_status = ST_ZERO_ID;
                end else if (hit_c) begin
                    wr_en           = 1'b1;
                    wr_word.surface = r_surf;
                end else if (r_free_found) begin
                    wr_en     = 1'b1;
                    set_valid = 1'b1;
                    wr_idx    = r_free_idx;
                    wr_word   = '{id: r_key, surface: r_surf, mapped: 1'b0};
                end else begin
                    n_status = ST_FULL;
                end
            end
            OP_MAP, OP_UNMAP: begin
                if (!hit_c) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    wr_en          = 1'b1;
                    wr_word.mapped = (r_op == OP_MAP);
                end
            end
            OP_QUERY: begin
                if (!hit_c) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    n_mapped = hit_word_c.mapped;
                end
            end
            default: begin
                n_status = ST_NOT_FOUND;
            end
        endcase
    end

    // entry memory: one read port, one write port
    always_ff @(posedge i_clk) begin
        r_rd_word <= r_mem[r_addr];
        if (finish_go && wr_en) begin
            r_mem[wr_idx] <= wr_word;
        end
    end

    // request latch and scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op   <= i_op;
            r_key  <= i_window_id;
            r_surf <= i_surface;
        end
        r_rd_idx <= r_addr;
        if (r_state == S_SCAN) begin
            r_hit_idx  <= hit_idx_c;
            r_hit_word <= hit_word_c;
            if (!r_free_found && !r_valid[r_addr]) begin
                r_free_idx <= r_addr;
            end
        end
    end

    // state machine, valid marks and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_addr       <= '0;
            r_rd_vld     <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
            r_status     <= ST_OK;
            r_mapped     <= 1'b0;
        end else begin
            // result valid: load on finish, drop once taken
            if (finish_go) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_rd_vld <= 1'b0;
                    if (in_accept) begin
                        r_addr       <= '0;
                        r_found      <= 1'b0;
                        r_free_found <= 1'b0;
                        r_state      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_rd_vld <= 1'b1;
                    r_found  <= hit_c;
                    if (!r_valid[r_addr]) begin
                        r_free_found <= 1'b1;
                    end
                    if (r_addr == LAST_IDX) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_addr <= r_addr + IW'(1);
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        if (set_valid) begin
                            r_valid[wr_idx] <= 1'b1;
                        end
                        r_status    <= n_status;
                        r_mapped    <= n_mapped;
                        r_rd_vld    <= 1'b0;
                        r_addr      <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_mapped    = r_mapped;

endmodule
// ----------------------------------------------------------------------------
`default_nettype wire
